>>> hdl/cdq_pkg.sv
// Shared types and codes for the circular deque.
// Request and result structs, operation and status codes, back-end states.
// No dependencies.
`default_nettype none

package cdq_pkg;

    localparam int KIND_W = 4;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 11;
    localparam int CNT_W  = 11;

    // Request kind codes as they arrive on the command port
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 4'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 4'd1;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 4'd2;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 4'd3;
    localparam logic [KIND_W-1:0] KIND_READ_FRONT = 4'd4;
    localparam logic [KIND_W-1:0] KIND_READ_BACK  = 4'd5;
    localparam logic [KIND_W-1:0] KIND_READ_INDEX = 4'd6;
    localparam logic [KIND_W-1:0] KIND_CLEAR      = 4'd7;
    localparam logic [KIND_W-1:0] KIND_RESIZE     = 4'd8;

    typedef enum logic [3:0] {
        OP_PUSH_BACK,
        OP_PUSH_FRONT,
        OP_POP_BACK,
        OP_POP_FRONT,
        OP_READ_FRONT,
        OP_READ_BACK,
        OP_READ_INDEX,
        OP_CLEAR,
        OP_RESIZE,
        OP_NOP
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_RANGE = 2'd2,
        ST_OVER  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_FILL
    } back_state_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [VAL_W-1:0]  value;
        logic [POS_W-1:0]  position;
    } cmd_t;

    typedef struct packed {
        logic [VAL_W-1:0] read_data;
        logic [CNT_W-1:0] count;
        logic             is_empty;
        logic             is_full;
        status_t          status;
    } rsp_t;

    // Classified request as it sits in the queue between front and back
    typedef struct packed {
        op_t              op;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] position;
    } entry_t;

endpackage

`default_nettype wire

>>> hdl/cdq_front.sv
// Front end of the circular deque: accepts requests and classifies them.
// Depends on cdq_pkg.
`default_nettype none

module cdq_front (
    input  wire logic           start,
    input  wire cdq_pkg::cmd_t  cmd,
    input  wire logic           q_full,
    output logic                busy,
    output logic                q_push,
    output cdq_pkg::entry_t     q_entry
);
    import cdq_pkg::*;

    op_t op;

    // Decode the kind; unused codes become a no-op
    always_comb
    begin
        unique case (cmd.kind)
            KIND_PUSH_BACK:  op = OP_PUSH_BACK;
            KIND_PUSH_FRONT: op = OP_PUSH_FRONT;
            KIND_POP_BACK:   op = OP_POP_BACK;
            KIND_POP_FRONT:  op = OP_POP_FRONT;
            KIND_READ_FRONT: op = OP_READ_FRONT;
            KIND_READ_BACK:  op = OP_READ_BACK;
            KIND_READ_INDEX: op = OP_READ_INDEX;
            KIND_CLEAR:      op = OP_CLEAR;
            KIND_RESIZE:     op = OP_RESIZE;
            default:         op = OP_NOP;
        endcase
    end

    assign busy             = q_full;
    assign q_push           = start && !q_full;
    assign q_entry.op       = op;
    assign q_entry.value    = cmd.value;
    assign q_entry.position = cmd.position;

endmodule

`default_nettype wire

>>> hdl/cdq_queue.sv
// Two-entry request queue between front and back of the circular deque.
// Depends on cdq_pkg.
`default_nettype none

module cdq_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire cdq_pkg::entry_t  push_entry,
    input  wire logic             pop,
    output logic                  full,
    output logic                  valid,
    output cdq_pkg::entry_t       head_entry
);
    import cdq_pkg::*;

    entry_t     entries_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    assign full       = (fill_reg == 2'd2);
    assign valid      = (fill_reg != 2'd0);
    assign head_entry = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

>>> hdl/cdq_back.sv
// Back end of the circular deque: pointers, element store and results.
// Depends on cdq_pkg.
`default_nettype none

module cdq_back #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    input  wire cdq_pkg::entry_t  q_entry,
    output logic                  q_pop,
    output logic                  done,
    output cdq_pkg::rsp_t         rsp
);
    import cdq_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OW = $clog2(DEPTH + 1);
    localparam int AW = PW + 1;
    localparam int XW = (OW > POS_W) ? OW : POS_W;
    localparam int SW = (DATA_WIDTH < VAL_W) ? DATA_WIDTH : VAL_W;

    back_state_t    state_reg;
    back_state_t    state_next;
    logic [PW-1:0]  head_reg;
    logic [PW-1:0]  head_next;
    logic [PW-1:0]  tail_reg;
    logic [PW-1:0]  tail_next;
    logic [OW-1:0]  occ_reg;
    logic [OW-1:0]  occ_next;
    entry_t         cur_reg;
    entry_t         cur_next;
    logic           done_reg;
    logic           done_next;
    rsp_t           rsp_reg;
    rsp_t           rsp_next;

    logic [SW-1:0]  slots [DEPTH];
    logic [SW-1:0]  rdata_reg;
    logic           mem_we;
    logic [PW-1:0]  mem_waddr;
    logic [SW-1:0]  mem_wdata;
    logic           mem_re;
    logic [PW-1:0]  mem_raddr;

    logic [XW-1:0]  pos_x;
    logic [XW-1:0]  occ_x;
    logic [XW-1:0]  fill_pos_x;
    logic           need_read;
    logic           need_fill;
    logic           fill_last;
    logic [PW-1:0]  put_ptr;

    function automatic logic [PW-1:0] inc_pos(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] dec_pos(input logic [PW-1:0] p);
        return (p == '0) ? PW'(DEPTH - 1) : p - 1'b1;
    endfunction

    function automatic logic [PW-1:0] at_offset(input logic [PW-1:0] h,
                                                input logic [PW-1:0] off);
        logic [AW-1:0] s;
        s = AW'(h) + AW'(off);
        if (s >= AW'(DEPTH))
        begin
            s = s - AW'(DEPTH);
        end
        return s[PW-1:0];
    endfunction

    function automatic rsp_t make_rsp(input logic [VAL_W-1:0] rd,
                                      input logic [OW-1:0] occ,
                                      input status_t st);
        rsp_t r;
        r.read_data = rd;
        r.count     = CNT_W'(occ);
        r.is_empty  = (occ == '0);
        r.is_full   = (occ == OW'(DEPTH));
        r.status    = st;
        return r;
    endfunction

    assign pos_x      = XW'(q_entry.position);
    assign occ_x      = XW'(occ_reg);
    assign fill_pos_x = XW'(cur_reg.position);

    always_comb
    begin
        need_read = 1'b0;
        need_fill = 1'b0;
        case (q_entry.op) inside
            OP_READ_FRONT, OP_READ_BACK: need_read = (occ_reg != '0);
            OP_READ_INDEX:               need_read = (pos_x < occ_x);
            OP_RESIZE:                   need_fill = (pos_x <= XW'(DEPTH)) &&
                                                     (pos_x > occ_x);
            default:                     need_read = 1'b0;
        endcase
        fill_last = ((occ_x + XW'(1)) == fill_pos_x);
        // Back slot for an append: restart at zero when empty
        put_ptr   = (occ_reg == '0) ? '0 : inc_pos(tail_reg);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && need_read)
                begin
                    state_next = BK_READ;
                end
                else if (q_valid && need_fill)
                begin
                    state_next = BK_FILL;
                end
            end
            BK_READ: state_next = BK_IDLE;
            BK_FILL:
            begin
                if (fill_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        occ_next  = occ_reg;
        cur_next  = cur_reg;
        done_next = 1'b0;
        rsp_next  = rsp_reg;
        q_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = put_ptr;
        mem_wdata = cur_reg.value[SW-1:0];
        mem_re    = 1'b0;
        mem_raddr = head_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    cur_next  = q_entry;
                    done_next = !need_read && !need_fill;
                    rsp_next  = make_rsp('0, occ_reg, ST_OK);
                    mem_wdata = q_entry.value[SW-1:0];
                    case (q_entry.op) inside
                        OP_PUSH_BACK, OP_PUSH_FRONT:
                        begin
                            if (occ_reg == OW'(DEPTH))
                            begin
                                rsp_next = make_rsp('0, occ_reg, ST_OVER);
                            end
                            else
                            begin
                                mem_we   = 1'b1;
                                occ_next = occ_reg + 1'b1;
                                if (occ_reg == '0)
                                begin
                                    head_next = '0;
                                    tail_next = '0;
                                    mem_waddr = '0;
                                end
                                else if (q_entry.op == OP_PUSH_BACK)
                                begin
                                    tail_next = inc_pos(tail_reg);
                                    mem_waddr = inc_pos(tail_reg);
                                end
                                else
                                begin
                                    head_next = dec_pos(head_reg);
                                    mem_waddr = dec_pos(head_reg);
                                end
                                rsp_next = make_rsp('0, occ_reg + 1'b1, ST_OK);
                            end
                        end
                        OP_POP_BACK, OP_POP_FRONT:
                        begin
                            if (occ_reg == '0)
                            begin
                                rsp_next = make_rsp('0, occ_reg, ST_UNDER);
                            end
                            else if (occ_reg == OW'(1))
                            begin
                                occ_next  = '0;
                                head_next = '0;
                                tail_next = '0;
                                rsp_next  = make_rsp('0, '0, ST_OK);
                            end
                            else
                            begin
                                occ_next = occ_reg - 1'b1;
                                if (q_entry.op == OP_POP_BACK)
                                begin
                                    tail_next = dec_pos(tail_reg);
                                end
                                else
                                begin
                                    head_next = inc_pos(head_reg);
                                end
                                rsp_next = make_rsp('0, occ_reg - 1'b1, ST_OK);
                            end
                        end
                        OP_READ_FRONT, OP_READ_BACK:
                        begin
                            if (occ_reg == '0)
                            begin
                                rsp_next = make_rsp('0, occ_reg, ST_UNDER);
                            end
                            else
                            begin
                                mem_re    = 1'b1;
                                mem_raddr = (q_entry.op == OP_READ_FRONT) ?
                                            head_reg : tail_reg;
                            end
                        end
                        OP_READ_INDEX:
                        begin
                            if (pos_x >= occ_x)
                            begin
                                rsp_next = make_rsp('0, occ_reg, ST_RANGE);
                            end
                            else
                            begin
                                mem_re    = 1'b1;
                                mem_raddr = at_offset(head_reg, PW'(q_entry.position));
                            end
                        end
                        OP_CLEAR:
                        begin
                            occ_next  = '0;
                            head_next = '0;
                            tail_next = '0;
                            rsp_next  = make_rsp('0, '0, ST_OK);
                        end
                        OP_RESIZE:
                        begin
                            if (pos_x > XW'(DEPTH))
                            begin
                                rsp_next = make_rsp('0, occ_reg, ST_OVER);
                            end
                            else if (pos_x == '0)
                            begin
                                occ_next  = '0;
                                head_next = '0;
                                tail_next = '0;
                                rsp_next  = make_rsp('0, '0, ST_OK);
                            end
                            else if (pos_x < occ_x)
                            begin
                                occ_next  = OW'(q_entry.position);
                                tail_next = at_offset(head_reg,
                                                      PW'(q_entry.position - 1'b1));
                                rsp_next  = make_rsp('0, OW'(q_entry.position), ST_OK);
                            end
                        end
                        default:
                        begin
                            rsp_next = make_rsp('0, occ_reg, ST_OK);
                        end
                    endcase
                end
            end
            BK_READ:
            begin
                done_next = 1'b1;
                rsp_next  = make_rsp(VAL_W'(rdata_reg), occ_reg, ST_OK);
            end
            BK_FILL:
            begin
                // Append one fill element per cycle
                mem_we    = 1'b1;
                occ_next  = occ_reg + 1'b1;
                tail_next = put_ptr;
                if (occ_reg == '0)
                begin
                    head_next = '0;
                end
                done_next = fill_last;
                rsp_next  = make_rsp('0, occ_reg + 1'b1, ST_OK);
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            occ_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            occ_reg   <= occ_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slots[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= slots[mem_raddr];
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

>>> hdl/circular_deque.sv
// Circular deque: an accepted request is written into the request queue, and the back end
// registers its result and result strobe; a read also passes the registered store read, and
// a growing resize first appends its elements in the fill state. The back end retires one
// single-access request per cycle while idle; a read or a growing resize holds it busy.
// Reset empties the deque and the request queue; the element store is not cleared.
// Results cannot be stalled; busy rises only while the two-entry request queue is full.
`default_nettype none

module circular_deque #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire cdq_pkg::cmd_t  cmd,
    output logic                done,
    output cdq_pkg::rsp_t       rsp
);
    import cdq_pkg::*;

    // Classified request travelling from front to back
    entry_t front_entry;
    entry_t back_entry;
    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_valid;

    // Front: take a request whenever the queue has room and classify it
    cdq_front u_front (
        .start   (start),
        .cmd     (cmd),
        .q_full  (q_full),
        .busy    (busy),
        .q_push  (q_push),
        .q_entry (front_entry)
    );

    // Queue: hold up to two classified requests so each side stalls on its own
    cdq_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (front_entry),
        .pop        (q_pop),
        .full       (q_full),
        .valid      (q_valid),
        .head_entry (back_entry)
    );

    // Back: advance the pointers, access the store, register one result
    cdq_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_entry (back_entry),
        .q_pop   (q_pop),
        .done    (done),
        .rsp     (rsp)
    );

endmodule

`default_nettype wire

>>> hdl/cdq_checker.sv
// Port-level checks on the circular deque, bound to the top level.
// Depends on cdq_pkg and circular_deque.
`default_nettype none

module cdq_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire cdq_pkg::cmd_t  cmd,
    input wire logic           done,
    input wire cdq_pkg::rsp_t  rsp
);
    import cdq_pkg::*;

    // The empty flag tracks the reported count
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.is_empty == (rsp.count == '0)))
        else $error("empty flag disagrees with count");

    // Any refused or failed request carries zero read data
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != ST_OK) |-> (rsp.read_data == '0))
        else $error("failed request returned data");

    // Underflow is only ever reported on an empty deque
    a_under_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == ST_UNDER) |-> (rsp.is_empty && !rsp.is_full))
        else $error("underflow on a non-empty deque");

    // The request queue can only fill up right after a request is taken
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && !busy))
        else $error("busy rose without a request");

    // A request taken by the block is fully driven
    a_cmd_known: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> !$isunknown(cmd))
        else $error("request taken with unknown fields");

endmodule

bind circular_deque cdq_checker u_cdq_checker (.*);

`default_nettype wire

>>> dv/circular_deque_check.sv
// Checker for the circular deque: watches the request and result channels, predicts each
// result from its own model of the deque and compares the two field by field.
// Depends on cdq_pkg for the request and result structs and the kind and status codes.
`default_nettype none

module circular_deque_check #(
    parameter int DEPTH = 1024
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          busy,
    input  wire cdq_pkg::cmd_t cmd,
    input  wire logic          done,
    input  wire cdq_pkg::rsp_t rsp,
    output int                 mismatches,
    output int                 outstanding
);
    import cdq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);

    // Model state of the deque
    logic [VAL_W-1:0] slots [DEPTH];
    logic [PTR_W-1:0] head;
    logic [PTR_W-1:0] tail;
    logic [CNT_W-1:0] occupancy;

    // Predicted results still owed by the block, oldest first
    rsp_t pending_rsp [$];

    function automatic logic [PTR_W-1:0] step_up(input logic [PTR_W-1:0] p);
        return (int'(p) == DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
    endfunction

    // Store position of the element that lies off places behind the front
    function automatic logic [PTR_W-1:0] slot_at(input logic [CNT_W-1:0] off);
        int p;
        p = int'(head) + int'(off);
        if (p >= DEPTH)
            p = p - DEPTH;
        return PTR_W'(p);
    endfunction

    task automatic empty_out();
        occupancy = '0;
        head      = '0;
        tail      = '0;
    endtask

    task automatic store_back(input logic [VAL_W-1:0] v);
        if (occupancy == '0)
        begin
            head = '0;
            tail = '0;
        end
        else
            tail = step_up(tail);
        slots[tail] = v;
        occupancy   = occupancy + 1'b1;
    endtask

    // Apply one request to the model and work out the result it owes
    task automatic apply_request(input cmd_t c, output rsp_t r);
        logic [VAL_W-1:0] word;
        status_t          st;
        word = '0;
        st   = ST_OK;
        case (c.kind)
            KIND_PUSH_BACK, KIND_PUSH_FRONT:
            begin
                if (int'(occupancy) >= DEPTH)
                    st = ST_OVER;
                else if (c.kind == KIND_PUSH_BACK)
                    store_back(c.value);
                else
                begin
                    if (occupancy == '0)
                    begin
                        head = '0;
                        tail = '0;
                    end
                    else
                        head = step_down(head);
                    slots[head] = c.value;
                    occupancy   = occupancy + 1'b1;
                end
            end
            KIND_POP_BACK, KIND_POP_FRONT:
            begin
                if (occupancy == '0)
                    st = ST_UNDER;
                else if (occupancy == 1)
                    empty_out();
                else
                begin
                    occupancy = occupancy - 1'b1;
                    if (c.kind == KIND_POP_BACK)
                        tail = step_down(tail);
                    else
                        head = step_up(head);
                end
            end
            KIND_READ_FRONT, KIND_READ_BACK:
            begin
                if (occupancy == '0)
                    st = ST_UNDER;
                else
                    word = slots[(c.kind == KIND_READ_FRONT) ? head : tail];
            end
            KIND_READ_INDEX:
            begin
                if (c.position >= occupancy)
                    st = ST_RANGE;
                else
                    word = slots[slot_at(c.position)];
            end
            KIND_CLEAR:
                empty_out();
            KIND_RESIZE:
            begin
                if (int'(c.position) > DEPTH)
                    st = ST_OVER;
                else if (c.position == '0)
                    empty_out();
                else if (c.position < occupancy)
                begin
                    occupancy = c.position;
                    tail      = slot_at(c.position - 1'b1);
                end
                else
                    while (occupancy < c.position)
                        store_back(c.value);
            end
            default:
                ;
        endcase
        r.read_data = word;
        r.count     = occupancy;
        r.is_empty  = (occupancy == '0);
        r.is_full   = (int'(occupancy) == DEPTH);
        r.status    = st;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            empty_out();
            pending_rsp.delete();
            mismatches = 0;
        end
        else
        begin
            // results first: a request accepted at this edge cannot be answered at it
            if (done === 1'b1)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $error("result with no request waiting: count %0d, status %0d",
                           rsp.count, rsp.status);
                    mismatches++;
                end
                else
                begin
                    want = pending_rsp[0];
                    pending_rsp.delete(0);
                    check_field("read_data", want.read_data, rsp.read_data);
                    check_field("count", 32'(want.count), 32'(rsp.count));
                    check_field("is_empty", 32'(want.is_empty), 32'(rsp.is_empty));
                    check_field("is_full", 32'(want.is_full), 32'(rsp.is_full));
                    check_field("status", 32'(want.status), 32'(rsp.status));
                end
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                apply_request(cmd, want);
                pending_rsp = {pending_rsp, want};
            end
        end
        outstanding = pending_rsp.size();
    end

endmodule

`default_nettype wire

>>> dv/circular_deque_test.sv
// Testbench top for the circular deque: clock, reset, stimulus and the final verdict.
// Depends on cdq_pkg, the circular_deque block and circular_deque_check, which does the
// prediction and comparison.
`default_nettype none

module circular_deque_test;
    import cdq_pkg::*;

    localparam int DEPTH    = 1024;
    // Wait this long after the last result for stray strobes: the longest request is a
    // resize that appends a whole deque's worth of elements.
    localparam int SETTLE   = DEPTH + 16;
    localparam int SEGMENTS = 15;
    localparam int SEG_LEN  = 102;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    cmd_t cmd   = '0;
    logic busy;
    logic done;
    rsp_t rsp;
    int   mismatches;
    int   outstanding;

    // 0: back-to-back requests; otherwise mostly back-to-back with short and long gaps
    int   gap_style = 1;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    circular_deque #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (VAL_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    circular_deque_check #(
        .DEPTH (DEPTH)
    ) deque_watch (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    function automatic cmd_t make_request(input logic [KIND_W-1:0] kind,
                                          input logic [VAL_W-1:0] value,
                                          input int position);
        cmd_t c;
        c.kind     = kind;
        c.value    = value;
        c.position = POS_W'(position);
        return c;
    endfunction

    // Most gaps short, a few long; none at all in back-to-back stretches
    function automatic int idle_cycles(input int style);
        int r;
        if (style == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // New size for a resize: mostly small, some anywhere up to the depth, some at the
    // very top so that the deque fills, and the rest over the whole field so that
    // refused sizes and the top position bit turn up.
    function automatic int resize_target();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return $urandom_range(0, 40);
        if (r < 75)
            return $urandom_range(41, DEPTH);
        if (r < 87)
            return $urandom_range(DEPTH - 4, DEPTH);
        return $urandom_range(0, (1 << POS_W) - 1);
    endfunction

    // fill_bias is the share of pushes in percent; the rest is spread over the other
    // kinds, so a high bias grows the deque towards full and a low one drains it.
    function automatic cmd_t random_request(input int fill_bias);
        cmd_t c;
        int   r;
        c.value    = $urandom;
        c.position = POS_W'($urandom_range(0, 31));
        r          = $urandom_range(0, 99);
        if (r < fill_bias)
        begin
            c.kind = ($urandom_range(0, 1) != 0) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
            return c;
        end
        r = $urandom_range(0, 99);
        if (r < 36)
            c.kind = ($urandom_range(0, 1) != 0) ? KIND_POP_FRONT : KIND_POP_BACK;
        else if (r < 52)
            c.kind = ($urandom_range(0, 1) != 0) ? KIND_READ_FRONT : KIND_READ_BACK;
        else if (r < 70)
            c.kind = KIND_READ_INDEX;
        else if (r < 73)
            c.kind = KIND_CLEAR;
        else if (r < 88)
        begin
            c.kind     = KIND_RESIZE;
            c.position = POS_W'(resize_target());
        end
        else if (r < 94)
            // kinds past resize are ignored by the block but still answered
            c.kind = KIND_W'($urandom_range(int'(KIND_RESIZE) + 1, (1 << KIND_W) - 1));
        else
        begin
            c.kind     = KIND_READ_INDEX;
            c.position = POS_W'($urandom_range(0, (1 << POS_W) - 1));
        end
        return c;
    endfunction

    // Present one request and hold it until the block takes it, then idle for a while.
    // start stays high into the next request when there is no gap, so it is never
    // lowered and raised at the same edge.
    task automatic issue(input cmd_t c);
        int   idle;
        cmd_t junk;
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        idle = idle_cycles(gap_style);
        if (idle > 0)
        begin
            // drive rubbish on the request port while start is low; it must be ignored
            junk.kind     = KIND_W'($urandom_range(0, (1 << KIND_W) - 1));
            junk.value    = $urandom;
            junk.position = POS_W'($urandom_range(0, (1 << POS_W) - 1));
            start <= 1'b0;
            cmd   <= junk;
            repeat (idle) @(posedge clk);
        end
    endtask

    initial
    begin
        int fill_bias;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: underflow and range errors on the empty deque
        issue(make_request(KIND_POP_BACK, 32'h0, 0));
        issue(make_request(KIND_POP_FRONT, 32'h0, 0));
        issue(make_request(KIND_READ_FRONT, 32'h0, 0));
        issue(make_request(KIND_READ_BACK, 32'h0, 0));
        issue(make_request(KIND_READ_INDEX, 32'h0, 0));
        // push into empty, then push at the front so that the head wraps round the store
        issue(make_request(KIND_PUSH_BACK, 32'hFFFF_FFFF, 0));
        issue(make_request(KIND_PUSH_FRONT, 32'h0000_0000, 0));
        issue(make_request(KIND_PUSH_FRONT, 32'hA5A5_A5A5, 0));
        issue(make_request(KIND_READ_FRONT, 32'h0, 0));
        issue(make_request(KIND_READ_BACK, 32'h0, 0));
        issue(make_request(KIND_READ_INDEX, 32'h0, 1));
        issue(make_request(KIND_READ_INDEX, 32'h0, 3));
        issue(make_request(KIND_READ_INDEX, 32'h0, (1 << POS_W) - 1));
        issue(make_request(KIND_POP_FRONT, 32'h0, 0));
        issue(make_request(KIND_POP_BACK, 32'h0, 0));
        // grow to full, then push and grow past the depth, which must be refused
        issue(make_request(KIND_RESIZE, 32'h5A5A_5A5A, DEPTH));
        issue(make_request(KIND_PUSH_BACK, 32'h1234_5678, 0));
        issue(make_request(KIND_PUSH_FRONT, 32'h8765_4321, 0));
        issue(make_request(KIND_RESIZE, 32'h0, (1 << POS_W) - 1));
        issue(make_request(KIND_RESIZE, 32'h0, DEPTH + 1));
        issue(make_request(KIND_READ_INDEX, 32'h0, DEPTH - 1));
        // resize to the same size, trim, an unknown kind, and resize to nothing
        issue(make_request(KIND_RESIZE, 32'hFFFF_FFFF, DEPTH));
        issue(make_request(KIND_RESIZE, 32'h0, 5));
        issue(make_request(KIND_W'((1 << KIND_W) - 1), 32'hFFFF_FFFF, (1 << POS_W) - 1));
        issue(make_request(KIND_RESIZE, 32'h0, 0));

        // Random: each segment picks filling, balanced or draining traffic at random,
        // each with its own idling style
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case ($urandom_range(0, 2))
                0:       fill_bias = 20;
                1:       fill_bias = 45;
                default: fill_bias = 75;
            endcase
            gap_style = $urandom_range(0, 3);
            repeat (SEG_LEN) issue(random_request(fill_bias));
        end

        // Drop start, let every owed result arrive, then watch for strays
        start <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("circular_deque_test passed");
        else
            $display("circular_deque_test failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, even with every resize a full growth
    initial
    begin
        #200_000_000;
        $display("circular_deque_test failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
hdl/cdq_pkg.sv
hdl/cdq_front.sv
hdl/cdq_queue.sv
hdl/cdq_back.sv
hdl/circular_deque.sv
hdl/cdq_checker.sv
dv/circular_deque_check.sv
dv/circular_deque_test.sv
